>>> hw/rtl/fkv_pkg.sv
package fkv_pkg;

    localparam int SLOTS       = 32;
    localparam int VALUE_BYTES = 65536;
    localparam int FULL_MARGIN = 5;

    localparam int KEY_W  = 32;
    localparam int LEN_W  = 17;
    localparam int OFF_W  = 16;
    localparam int SLOT_W = 5;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = LEN_W + 1;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_GET = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_NONE = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_GET,
        S_DEL,
        S_CPI,
        S_CPK,
        S_MOVE,
        S_ADD
    } t_state;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] size;
    } t_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_clr;

    typedef struct packed {
        logic             valid;
        logic             match;
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] size;
    } t_rd;

    typedef struct packed {
        logic [1:0]        status;
        logic              is_move;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  value_address;
        logic [OFF_W-1:0]  move_source;
        logic [LEN_W-1:0]  result_length;
        logic              last;
    } t_result;

endpackage

>>> hw/rtl/fkv_if.sv
interface fkv_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [fkv_pkg::KEY_W-1:0] key_code;
    logic [fkv_pkg::LEN_W-1:0] value_length;

    modport source (output valid, req_type, key_code, value_length, input ready);
    modport sink   (input valid, req_type, key_code, value_length, output ready);
endinterface

interface fkv_res_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic                      is_move;
    logic [fkv_pkg::SLOT_W-1:0] slot;
    logic [fkv_pkg::OFF_W-1:0]  value_address;
    logic [fkv_pkg::OFF_W-1:0]  move_source;
    logic [fkv_pkg::LEN_W-1:0]  result_length;
    logic                      last;

    modport source (output valid, status, is_move, slot, value_address, move_source,
                     result_length, last, input ready);
    modport sink   (input valid, status, is_move, slot, value_address, move_source,
                     result_length, last, output ready);
endinterface

>>> hw/rtl/fkv_store.sv
module fkv_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [fkv_pkg::IDX_W-1:0]     i_rd_idx,
    input  logic [fkv_pkg::KEY_W-1:0]     i_cmp_key,
    input  fkv_pkg::t_wr                  i_wr,
    input  fkv_pkg::t_clr                 i_clr,
    output fkv_pkg::t_rd                  o_rd
);

    logic [fkv_pkg::SLOTS-1:0] r_valid;
    logic [fkv_pkg::KEY_W-1:0] r_key  [fkv_pkg::SLOTS];
    logic [fkv_pkg::OFF_W-1:0] r_off  [fkv_pkg::SLOTS];
    logic [fkv_pkg::LEN_W-1:0] r_size [fkv_pkg::SLOTS];

    // A slot that is written in the same cycle as it is cleared stays valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_clr.en) begin
                r_valid[i_clr.idx] <= 1'b0;
            end
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key[i_wr.idx]  <= i_wr.key;
            r_off[i_wr.idx]  <= i_wr.off;
            r_size[i_wr.idx] <= i_wr.size;
        end
    end

    always_comb begin
        o_rd.valid = r_valid[i_rd_idx];
        o_rd.key   = r_key[i_rd_idx];
        o_rd.off   = r_off[i_rd_idx];
        o_rd.size  = r_size[i_rd_idx];
        o_rd.match = r_valid[i_rd_idx] && (r_key[i_rd_idx] == i_cmp_key);
    end

endmodule

>>> hw/rtl/fkv_seq.sv
module fkv_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    fkv_req_if.sink                   i_req,
    fkv_res_if.source                 o_res,
    output logic [fkv_pkg::IDX_W-1:0] o_rd_idx,
    output logic [fkv_pkg::KEY_W-1:0] o_cmp_key,
    output fkv_pkg::t_wr              o_wr,
    output fkv_pkg::t_clr             o_clr,
    input  fkv_pkg::t_rd              i_rd
);

    localparam logic [fkv_pkg::CNT_W-1:0] CNT_SLOTS = fkv_pkg::CNT_W'(fkv_pkg::SLOTS);
    localparam logic [fkv_pkg::CNT_W-1:0] CNT_TOP   = fkv_pkg::CNT_W'(fkv_pkg::SLOTS - 1);
    localparam logic [fkv_pkg::SUM_W-1:0] SUM_LIM   = fkv_pkg::SUM_W'(fkv_pkg::VALUE_BYTES);
    localparam logic [fkv_pkg::LEN_W-1:0] END_LIM   = fkv_pkg::LEN_W'(fkv_pkg::VALUE_BYTES);
    localparam logic [fkv_pkg::LEN_W-1:0] FULL_LIM  =
        fkv_pkg::LEN_W'(fkv_pkg::VALUE_BYTES - fkv_pkg::FULL_MARGIN);

    fkv_pkg::t_state r_state, n_state;

    logic [1:0]                r_req, n_req;
    logic [fkv_pkg::KEY_W-1:0] r_key, n_key;
    logic [fkv_pkg::LEN_W-1:0] r_len, n_len;
    logic [fkv_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [fkv_pkg::CNT_W-1:0] r_k, n_k;
    logic [fkv_pkg::CNT_W-1:0] r_t, n_t;
    logic [fkv_pkg::LEN_W-1:0] r_v, n_v;
    logic [fkv_pkg::KEY_W-1:0] r_ikey, n_ikey;
    fkv_pkg::t_status          r_rstat, n_rstat;
    logic [fkv_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [fkv_pkg::LEN_W-1:0] r_end, n_end;
    logic                      r_full, n_full;
    logic                      r_ovalid;
    fkv_pkg::t_result          r_res, n_res;

    logic accept;
    logic can_emit;
    logic emit;
    logic bad_req;
    logic add_over;
    logic pack_full;

    assign accept    = i_req.valid && i_req.ready;
    assign can_emit  = !r_ovalid || o_res.ready;
    assign bad_req   = (i_req.key_code == '0) || (i_req.req_type > fkv_pkg::REQ_DEL);
    assign add_over  = (r_cnt >= CNT_SLOTS) ||
                       (({1'b0, r_end} + {1'b0, r_len}) > SUM_LIM);
    assign pack_full = (r_t == CNT_SLOTS) || (r_v >= FULL_LIM);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fkv_pkg::S_IDLE: begin
                if (accept) begin
                    priority if (bad_req) begin
                        n_state = fkv_pkg::S_RESP;
                    end else if (i_req.req_type == fkv_pkg::REQ_GET) begin
                        n_state = fkv_pkg::S_GET;
                    end else if (i_req.req_type == fkv_pkg::REQ_DEL) begin
                        n_state = fkv_pkg::S_DEL;
                    end else if (i_req.value_length == '0 || r_full) begin
                        n_state = fkv_pkg::S_RESP;
                    end else if (r_cnt >= CNT_SLOTS || r_end >= END_LIM) begin
                        n_state = fkv_pkg::S_CPI;
                    end else begin
                        n_state = fkv_pkg::S_ADD;
                    end
                end
            end
            fkv_pkg::S_RESP, fkv_pkg::S_ADD: begin
                if (can_emit) begin
                    n_state = fkv_pkg::S_IDLE;
                end
            end
            fkv_pkg::S_GET: begin
                if (can_emit) begin
                    priority if (i_rd.match) begin
                        n_state = fkv_pkg::S_IDLE;
                    end else if (r_idx == '0) begin
                        n_state = fkv_pkg::S_RESP;
                    end
                end
            end
            fkv_pkg::S_DEL: begin
                if (r_idx == CNT_TOP) begin
                    n_state = fkv_pkg::S_RESP;
                end
            end
            fkv_pkg::S_CPI: begin
                priority if (r_idx == CNT_SLOTS) begin
                    n_state = pack_full ? fkv_pkg::S_RESP : fkv_pkg::S_ADD;
                end else if (i_rd.valid) begin
                    n_state = fkv_pkg::S_CPK;
                end
            end
            fkv_pkg::S_CPK: begin
                priority if (r_k == CNT_SLOTS) begin
                    n_state = fkv_pkg::S_MOVE;
                end else if (i_rd.match) begin
                    n_state = fkv_pkg::S_CPI;
                end
            end
            fkv_pkg::S_MOVE: begin
                if (can_emit) begin
                    n_state = fkv_pkg::S_CPI;
                end
            end
            default: n_state = fkv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_req     = r_req;
        n_key     = r_key;
        n_len     = r_len;
        n_idx     = r_idx;
        n_k       = r_k;
        n_t       = r_t;
        n_v       = r_v;
        n_ikey    = r_ikey;
        n_rstat   = r_rstat;
        n_cnt     = r_cnt;
        n_end     = r_end;
        n_full    = r_full;
        n_res     = '0;
        emit      = 1'b0;
        o_wr      = '0;
        o_clr     = '0;
        o_rd_idx  = r_idx[fkv_pkg::IDX_W-1:0];
        o_cmp_key = r_key;
        unique case (r_state)
            fkv_pkg::S_IDLE: begin
                if (accept) begin
                    n_req   = i_req.req_type;
                    n_key   = i_req.key_code;
                    n_len   = i_req.value_length;
                    n_idx   = (i_req.req_type == fkv_pkg::REQ_GET) ? CNT_TOP : '0;
                    n_t     = '0;
                    n_v     = '0;
                    n_rstat = fkv_pkg::ST_OK;
                    priority if (bad_req) begin
                        n_rstat = fkv_pkg::ST_ERR;
                    end else if (i_req.req_type != fkv_pkg::REQ_ADD) begin
                        n_rstat = fkv_pkg::ST_OK;
                    end else if (i_req.value_length == '0) begin
                        n_rstat = fkv_pkg::ST_ERR;
                    end else if (r_full) begin
                        n_rstat = fkv_pkg::ST_FULL;
                    end
                end
            end
            fkv_pkg::S_RESP: begin
                if (can_emit) begin
                    emit         = 1'b1;
                    n_res.status = r_rstat;
                    n_res.last   = 1'b1;
                end
            end
            fkv_pkg::S_GET: begin
                if (can_emit) begin
                    priority if (i_rd.match) begin
                        emit                = 1'b1;
                        n_res.status        = fkv_pkg::ST_OK;
                        n_res.slot          = fkv_pkg::SLOT_W'(r_idx);
                        n_res.value_address = i_rd.off;
                        n_res.result_length = i_rd.size;
                        n_res.last          = 1'b1;
                    end else if (r_idx == '0) begin
                        n_rstat = fkv_pkg::ST_NONE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            fkv_pkg::S_DEL: begin
                o_clr.en  = i_rd.match;
                o_clr.idx = r_idx[fkv_pkg::IDX_W-1:0];
                if (r_idx == CNT_TOP) begin
                    n_full  = 1'b0;
                    n_rstat = fkv_pkg::ST_OK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            fkv_pkg::S_CPI: begin
                priority if (r_idx == CNT_SLOTS) begin
                    n_cnt  = r_t;
                    n_end  = r_v;
                    n_full = pack_full;
                    if (pack_full) begin
                        n_rstat = fkv_pkg::ST_FULL;
                    end
                end else if (i_rd.valid) begin
                    n_ikey = i_rd.key;
                    n_k    = r_idx + 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            fkv_pkg::S_CPK: begin
                o_rd_idx  = r_k[fkv_pkg::IDX_W-1:0];
                o_cmp_key = r_ikey;
                priority if (r_k == CNT_SLOTS) begin
                    n_k = r_k;
                end else if (i_rd.match) begin
                    o_clr.en  = 1'b1;
                    o_clr.idx = r_idx[fkv_pkg::IDX_W-1:0];
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            fkv_pkg::S_MOVE: begin
                if (can_emit) begin
                    emit                = 1'b1;
                    n_res.status        = fkv_pkg::ST_OK;
                    n_res.is_move       = 1'b1;
                    n_res.slot          = fkv_pkg::SLOT_W'(r_t);
                    n_res.value_address = r_v[fkv_pkg::OFF_W-1:0];
                    n_res.move_source   = i_rd.off;
                    n_res.result_length = i_rd.size;
                    o_clr.en            = 1'b1;
                    o_clr.idx           = r_idx[fkv_pkg::IDX_W-1:0];
                    o_wr.en             = 1'b1;
                    o_wr.idx            = r_t[fkv_pkg::IDX_W-1:0];
                    o_wr.key            = r_ikey;
                    o_wr.off            = r_v[fkv_pkg::OFF_W-1:0];
                    o_wr.size           = i_rd.size;
                    n_v                 = r_v + i_rd.size;
                    n_t                 = r_t + 1'b1;
                    n_idx               = r_idx + 1'b1;
                end
            end
            fkv_pkg::S_ADD: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    n_res.last = 1'b1;
                    if (add_over) begin
                        n_res.status = fkv_pkg::ST_FULL;
                    end else begin
                        n_res.status        = fkv_pkg::ST_OK;
                        n_res.slot          = fkv_pkg::SLOT_W'(r_cnt);
                        n_res.value_address = r_end[fkv_pkg::OFF_W-1:0];
                        n_res.result_length = r_len;
                        o_wr.en             = 1'b1;
                        o_wr.idx            = r_cnt[fkv_pkg::IDX_W-1:0];
                        o_wr.key            = r_key;
                        o_wr.off            = r_end[fkv_pkg::OFF_W-1:0];
                        o_wr.size           = r_len;
                        n_cnt               = r_cnt + 1'b1;
                        n_end               = r_end + r_len;
                    end
                end
            end
            default: begin
                n_rstat = r_rstat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fkv_pkg::S_IDLE;
            r_cnt    <= '0;
            r_end    <= '0;
            r_full   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_end   <= n_end;
            r_full  <= n_full;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_key   <= n_key;
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_t     <= n_t;
        r_v     <= n_v;
        r_ikey  <= n_ikey;
        r_rstat <= n_rstat;
        if (emit) begin
            r_res <= n_res;
        end
    end

    assign i_req.ready         = (r_state == fkv_pkg::S_IDLE);
    assign o_res.valid         = r_ovalid;
    assign o_res.status        = r_res.status;
    assign o_res.is_move       = r_res.is_move;
    assign o_res.slot          = r_res.slot;
    assign o_res.value_address = r_res.value_address;
    assign o_res.move_source   = r_res.move_source;
    assign o_res.result_length = r_res.result_length;
    assign o_res.last          = r_res.last;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request accepted while a transaction was in progress");

    a_pack_below_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fkv_pkg::S_CPI || r_state == fkv_pkg::S_CPK ||
         r_state == fkv_pkg::S_MOVE) |-> (r_t <= r_idx))
        else $error("compaction target passed the scan index");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_SLOTS)
        else $error("slot count beyond the number of slots");

    a_end_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end <= END_LIM)
        else $error("value end beyond the value area");
`endif

endmodule

>>> hw/rtl/flash_kv_slot_index.sv
// Append-only slot index for a flash key-value area.
// Requests arrive on i_req (req_type, key_code, value_length) and results leave
// on o_res; both are valid/ready channels and a transaction completes when
// valid and ready are both high at a rising edge of i_clk.
// An add appends a slot at the running end of the value area; when the slots or
// the value space are used up it first compacts, emitting one move result per
// surviving slot with last low, followed by the answer with last high.
// A get searches from the top slot down, and a delete clears every matching slot.
// Each request is handled alone and i_req.ready is low until its final result is
// loaded into the output register. A get or a delete walks the slots one per
// cycle, a get only while the output register can take a result.
// Compaction compares each occupied slot against the higher slots one pair per
// cycle on the shared key comparator, up to the first slot with the same key.
// When the receiver holds o_res.ready low the sequencer waits with the next
// result, and no result is lost or repeated.
// A synchronous reset on i_rst_n empties every slot and clears the full flag
// and the value end.
module flash_kv_slot_index (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fkv_req_if.sink   i_req,
    fkv_res_if.source o_res
);

    logic [fkv_pkg::IDX_W-1:0] rd_idx;
    logic [fkv_pkg::KEY_W-1:0] cmp_key;
    fkv_pkg::t_wr              wr;
    fkv_pkg::t_clr             clr;
    fkv_pkg::t_rd              rd;

    fkv_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_res     (o_res),
        .o_rd_idx  (rd_idx),
        .o_cmp_key (cmp_key),
        .o_wr      (wr),
        .o_clr     (clr),
        .i_rd      (rd)
    );

    fkv_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (rd_idx),
        .i_cmp_key (cmp_key),
        .i_wr      (wr),
        .i_clr     (clr),
        .o_rd      (rd)
    );

endmodule
